// ----- hw/rtl/periodic_message_scheduler_macros.svh -----
// Assertion macros for the periodic message scheduler.
`ifndef PERIODIC_MESSAGE_SCHEDULER_MACROS_SVH
`define PERIODIC_MESSAGE_SCHEDULER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/pms_pkg.sv -----
// Shared types and codes of the periodic message scheduler.
package pms_pkg;

  typedef enum logic {
    KIND_REGISTER = 1'b0,
    KIND_POLL     = 1'b1
  } kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    logic        enabled;
    logic [7:0]  message_id;
    logic [15:0] period;
    logic [31:0] last_sent;
  } entry_t;

  localparam logic [31:0] STAMP_ZERO = 32'd0;

endpackage

// ----- hw/rtl/pms_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pms_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hw/rtl/pms_due_unit.sv -----
// Due check: wrapping elapsed time of one entry compared against its period.
module pms_due_unit
  import pms_pkg::*;
(
  input  entry_t      entry_i,
  input  logic [31:0] now_i,
  output logic        due_o
);

  logic [31:0] elapsed;

  assign elapsed = now_i - entry_i.last_sent;
  assign due_o   = entry_i.enabled && (elapsed >= {16'd0, entry_i.period});

endmodule

// ----- hw/rtl/periodic_message_scheduler.sv -----
// Top level of the periodic message scheduler: config register, sequencer and table.
//
//  channel  | handshake                     | payload
//  ---------+-------------------------------+-------------------------------------------
//  command  | start, busy                   | kind_i, message_id_i, send_period_i,
//           |                               | entry_enable_i, now_ms_i
//  result   | result_valid_o (one cycle)    | registered_o, due_found_o,
//           |                               | due_message_id_o, due_slot_o
//  config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// A register beat, and a poll while sending is disabled or the table is empty,
// gives its result in the cycle after it is accepted and keeps busy low.
// A poll that scans reads one table entry per cycle from the RAM into the due
// check; each entry is decided from the registered read data, and the result is
// registered after the first due entry or after the last entry is decided.
// After reset the table is empty and no clearing pass is needed.
// The receiver cannot stall, so each result beat lasts exactly one cycle.
`include "periodic_message_scheduler_macros.svh"

module periodic_message_scheduler
  import pms_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        kind_i,
  input  logic [7:0]  message_id_i,
  input  logic [15:0] send_period_i,
  input  logic        entry_enable_i,
  input  logic [31:0] now_ms_i,
  output logic        result_valid_o,
  output logic        registered_o,
  output logic        due_found_o,
  output logic [7:0]  due_message_id_o,
  output logic [3:0]  due_slot_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int ExtW = (IdxW > 4) ? IdxW : 4;
  localparam logic [CntW-1:0] DepthC = CntW'(TABLE_DEPTH);

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] scan_q;
  logic            disabled_q;
  logic            valid_q;
  logic            valid_d;
  logic            pend_q;
  logic [CntW-1:0] iss_left_q;
  logic [CntW-1:0] eval_left_q;
  logic [IdxW-1:0] iss_ptr_q;
  logic [IdxW-1:0] pend_addr_q;
  logic [IdxW-1:0] start_ptr_q;
  logic [31:0]     now_q;
  logic            registered_q;
  logic            found_q;
  logic [7:0]      id_q;
  logic [3:0]      slot_q;

  logic            accept;
  logic            can_store;
  logic            go_scan;
  logic [IdxW-1:0] start_ptr;
  logic            due;
  logic            hit;
  logic            last_eval;
  logic            finish;
  logic            ram_wr_en;
  logic [IdxW-1:0] ram_wr_addr;
  entry_t          ram_wr_data;
  logic            ram_rd_en;
  entry_t          ram_rd_data;
  logic [ExtW-1:0] slot_ext;

  function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] p,
                                               input logic [CntW-1:0] n);
    logic [CntW-1:0] nxt;
    nxt = CntW'(p) + CntW'(1);
    return (nxt == n) ? '0 : nxt[IdxW-1:0];
  endfunction

  assign accept    = start && (state_q == ST_IDLE);
  assign can_store = count_q < DepthC;
  assign go_scan   = (kind_e'(kind_i) == KIND_POLL) && !disabled_q && (count_q != '0);
  assign start_ptr = (CntW'(scan_q) < count_q) ? scan_q : '0;
  assign hit       = (state_q == ST_SCAN) && pend_q && due;
  assign last_eval = pend_q && (eval_left_q == CntW'(1));
  assign finish    = hit || last_eval;
  assign slot_ext  = ExtW'(pend_addr_q);
  assign valid_d   = (accept && !go_scan) || ((state_q == ST_SCAN) && finish);

  pms_ram #(
    .Width($bits(entry_t)),
    .Depth(TABLE_DEPTH)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (ram_wr_en),
    .wr_addr_i(ram_wr_addr),
    .wr_data_i(ram_wr_data),
    .rd_en_i  (ram_rd_en),
    .rd_addr_i(iss_ptr_q),
    .rd_data_o(ram_rd_data)
  );

  pms_due_unit u_due (
    .entry_i(ram_rd_data),
    .now_i  (now_q),
    .due_o  (due)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && go_scan) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = count_q[IdxW-1:0];
    ram_wr_data = '{enabled: entry_enable_i, message_id: message_id_i,
                    period: send_period_i, last_sent: STAMP_ZERO};
    ram_rd_en   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        ram_wr_en = accept && (kind_e'(kind_i) == KIND_REGISTER) && can_store;
      end
      ST_SCAN: begin
        ram_wr_en             = hit;
        ram_wr_addr           = pend_addr_q;
        ram_wr_data           = ram_rd_data;
        ram_wr_data.last_sent = now_q;
        ram_rd_en             = (iss_left_q != '0) && !finish;
      end
      default: begin
        ram_wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      disabled_q  <= 1'b0;
      valid_q     <= 1'b0;
      pend_q      <= 1'b0;
      iss_left_q  <= '0;
      eval_left_q <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      if (psel && penable && pwrite && !paddr[2]) begin
        disabled_q <= pwdata[0];
      end
      case (state_q)
        ST_IDLE: begin
          pend_q <= 1'b0;
          if (accept) begin
            if (kind_e'(kind_i) == KIND_REGISTER) begin
              if (can_store) begin
                count_q <= count_q + CntW'(1);
              end
            end else if (go_scan) begin
              iss_left_q  <= count_q;
              eval_left_q <= count_q;
            end
          end
        end
        ST_SCAN: begin
          pend_q <= ram_rd_en;
          if (ram_rd_en) begin
            iss_left_q <= iss_left_q - CntW'(1);
          end
          if (pend_q) begin
            eval_left_q <= eval_left_q - CntW'(1);
          end
          if (hit) begin
            scan_q <= wrap_inc(pend_addr_q, count_q);
          end else if (last_eval) begin
            scan_q <= start_ptr_q;
          end
        end
        default: begin
          pend_q <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          registered_q <= (kind_e'(kind_i) == KIND_REGISTER) && can_store;
          found_q      <= 1'b0;
          id_q         <= '0;
          slot_q       <= '0;
          now_q        <= now_ms_i;
          iss_ptr_q    <= start_ptr;
          start_ptr_q  <= start_ptr;
        end
      end
      ST_SCAN: begin
        if (ram_rd_en) begin
          iss_ptr_q   <= wrap_inc(iss_ptr_q, count_q);
          pend_addr_q <= iss_ptr_q;
        end
        if (hit) begin
          registered_q <= 1'b0;
          found_q      <= 1'b1;
          id_q         <= ram_rd_data.message_id;
          slot_q       <= slot_ext[3:0];
        end else if (last_eval) begin
          registered_q <= 1'b0;
          found_q      <= 1'b0;
          id_q         <= '0;
          slot_q       <= '0;
        end
      end
      default: begin
        found_q <= 1'b0;
      end
    endcase
  end

  assign busy             = (state_q != ST_IDLE);
  assign result_valid_o   = valid_q;
  assign registered_o     = registered_q;
  assign due_found_o      = found_q;
  assign due_message_id_o = id_q;
  assign due_slot_o       = slot_q;
  assign prdata           = paddr[2] ? 32'd0 : {31'd0, disabled_q};
  assign pready           = 1'b1;

  `PMS_ASSERT_NOW(a_result_when_idle, result_valid_o, state_q == ST_IDLE,
                  "result beat while a scan is running")
  `PMS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= DepthC, "entry count beyond table depth")
  `PMS_ASSERT_NOW(a_pointer_bound, count_q != '0, CntW'(scan_q) < count_q,
                  "scan pointer outside the filled table")
  `PMS_ASSERT_NEXT(a_register_answer, accept && (kind_e'(kind_i) == KIND_REGISTER),
                   result_valid_o && !due_found_o, "register beat without its answer")

endmodule
